// File: rtl/core/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// tmcw_pkg: shared types and constants of the text mode console writer
// payload widths, operation and state codes, control characters, cell helper
// ----------------------------------------------------------------------------
package tmcw_pkg;

   // payload widths
   localparam int OPCODE_W     = 2;
   localparam int CHAR_W       = 8;
   localparam int COORD_W      = 8;
   localparam int POS_W        = 11;
   localparam int COLUMN_OUT_W = 7;
   localparam int ROW_OUT_W    = 5;
   localparam int CELL_W       = 16;
   localparam int ATTR_W       = 8;
   localparam int NIBBLE_W     = 4;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 8;

   // screen geometry defaults
   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS    = 25;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ATTR_FOREGROUND = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTR_BACKGROUND = 4'd1;

   // attribute reset values
   localparam logic [NIBBLE_W-1:0] FOREGROUND_RESET = 4'h7;
   localparam logic [NIBBLE_W-1:0] BACKGROUND_RESET = 4'h0;

   // control characters
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   // screen contents right after reset: space, light grey on black
   localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUT_CHAR   = 2'd0,
      OP_SET_CURSOR = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_READ_CELL  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_COPY,
      ST_COPY_TAIL,
      ST_FILL,
      ST_DONE
   } ctrl_state_type;

   // attribute in the high byte, character in the low byte
   function automatic logic [CELL_W-1:0] cell_of(input logic [ATTR_W-1:0] attr,
                                                 input logic [CHAR_W-1:0] ch);
      return {attr, ch};
   endfunction

endpackage

// File: rtl/core/tmcw_ifs.sv
// ----------------------------------------------------------------------------
// tmcw channel interfaces
// request, response and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface tmcw_req_if;
   logic                             valid;
   logic                             ready;
   logic [tmcw_pkg::OPCODE_W-1:0]    opcode;
   logic [tmcw_pkg::CHAR_W-1:0]      char_code;
   logic [tmcw_pkg::COORD_W-1:0]     column;
   logic [tmcw_pkg::COORD_W-1:0]     row;

   modport source (output valid, opcode, char_code, column, row, input ready);
   modport sink   (input valid, opcode, char_code, column, row, output ready);
endinterface

interface tmcw_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tmcw_pkg::POS_W-1:0]          cursor_position;
   logic [tmcw_pkg::COLUMN_OUT_W-1:0]   cursor_column;
   logic [tmcw_pkg::ROW_OUT_W-1:0]      cursor_row;
   logic [tmcw_pkg::CELL_W-1:0]         cell_data;

   modport source (output valid, cursor_position, cursor_column, cursor_row, cell_data,
                   input ready);
   modport sink   (input valid, cursor_position, cursor_column, cursor_row, cell_data,
                   output ready);
endinterface

interface tmcw_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tmcw_pkg::CSR_INDEX_W-1:0]    index;
   logic [tmcw_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/text_mode_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer_core: text screen writer with cursor
// attribute registers, screen cell store and operation sequencer
// ----------------------------------------------------------------------------
// A request beat carries one operation: put character, set cursor, clear or
// read cell; each gives exactly one response beat with the cursor after the
// operation (and the cell for a read). Operations run one at a time; the
// screen contents live in one single-port-write, registered-read cell memory
// of COLUMNS*ROWS entries, the cursor and attributes in registers. A request
// is taken in the idle state and executed in the next; a read cell passes through
// the registered memory read before it answers. Clear sweeps the memory one
// cell a cycle. A put that runs off the last row scrolls: one copy pass over
// (ROWS-1)*COLUMNS cells plus a blank pass over COLUMNS cells. After reset a
// clearing pass over all COLUMNS*ROWS cells (2000 at 80x25) fills the screen
// with space on attribute 0x07 before the first request beat is taken;
// register writes are accepted throughout. The response sits in an output
// register, so the next request beat is taken while a response still waits
// for its consumer. Register writes belong in idle time only.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core #(
   parameter int COLUMNS = tmcw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tmcw_pkg::DEFAULT_ROWS
) (
   input logic        clock,
   input logic        reset,
   tmcw_req_if.sink   req_ch,
   tmcw_rsp_if.source rsp_ch,
   tmcw_csr_if.sink   csr_ch
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   // attribute registers, low nibble of each write is kept
   logic [tmcw_pkg::NIBBLE_W-1:0] fg_ff, fg_in;
   logic [tmcw_pkg::NIBBLE_W-1:0] bg_ff, bg_in;
   logic                          csr_write;

   // store ports
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [tmcw_pkg::CELL_W-1:0] wr_data;
   logic                        rd_en;
   logic [ADDR_W-1:0]           rd_addr;
   logic [tmcw_pkg::CELL_W-1:0] rd_data;

   // register port never stalls
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_write) begin
         case (csr_ch.index)
            tmcw_pkg::REG_ATTR_FOREGROUND: fg_in = csr_ch.data[tmcw_pkg::NIBBLE_W-1:0];
            tmcw_pkg::REG_ATTR_BACKGROUND: bg_in = csr_ch.data[tmcw_pkg::NIBBLE_W-1:0];
            default: begin
               // unknown index, write is dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= tmcw_pkg::FOREGROUND_RESET;
         bg_ff <= tmcw_pkg::BACKGROUND_RESET;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   // cell store
   tmcw_screen_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer with cursor and response register
   tmcw_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .ADDR_W  (ADDR_W)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_ch.valid),
      .req_ready           (req_ch.ready),
      .req_opcode          (req_ch.opcode),
      .req_char_code       (req_ch.char_code),
      .req_column          (req_ch.column),
      .req_row             (req_ch.row),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_cursor_position (rsp_ch.cursor_position),
      .rsp_cursor_column   (rsp_ch.cursor_column),
      .rsp_cursor_row      (rsp_ch.cursor_row),
      .rsp_cell_data       (rsp_ch.cell_data),
      .attr                ({bg_ff, fg_ff}),
      .wr_en               (wr_en),
      .wr_addr             (wr_addr),
      .wr_data             (wr_data),
      .rd_en               (rd_en),
      .rd_addr             (rd_addr),
      .rd_data             (rd_data)
   );

endmodule

// File: rtl/core/tmcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tmcw_screen_ram: screen cell store
// one write port, one read port, read data registered (adds read latency)
// ----------------------------------------------------------------------------
module tmcw_screen_ram #(
   parameter int DEPTH  = tmcw_pkg::DEFAULT_COLUMNS * tmcw_pkg::DEFAULT_ROWS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [tmcw_pkg::CELL_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [tmcw_pkg::CELL_W-1:0] rd_data
);

   logic [tmcw_pkg::CELL_W-1:0] mem [DEPTH];
   logic [tmcw_pkg::CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/tmcw_ctrl.sv
// ----------------------------------------------------------------------------
// tmcw_ctrl: operation sequencer of the console writer
// holds the cursor, drives the screen store, sweeps for init, clear and scroll
// ----------------------------------------------------------------------------
module tmcw_ctrl #(
   parameter int COLUMNS = tmcw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tmcw_pkg::DEFAULT_ROWS,
   parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
   input  logic                              clock,
   input  logic                              reset,
   // request side
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tmcw_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [tmcw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tmcw_pkg::COORD_W-1:0]      req_column,
   input  logic [tmcw_pkg::COORD_W-1:0]      req_row,
   // response side
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tmcw_pkg::POS_W-1:0]        rsp_cursor_position,
   output logic [tmcw_pkg::COLUMN_OUT_W-1:0] rsp_cursor_column,
   output logic [tmcw_pkg::ROW_OUT_W-1:0]    rsp_cursor_row,
   output logic [tmcw_pkg::CELL_W-1:0]       rsp_cell_data,
   // current attribute
   input  logic [tmcw_pkg::ATTR_W-1:0]       attr,
   // screen store
   output logic                              wr_en,
   output logic [ADDR_W-1:0]                 wr_addr,
   output logic [tmcw_pkg::CELL_W-1:0]       wr_data,
   output logic                              rd_en,
   output logic [ADDR_W-1:0]                 rd_addr,
   input  logic [tmcw_pkg::CELL_W-1:0]       rd_data
);

   localparam int CELLS        = COLUMNS * ROWS;
   localparam int COL_W        = $clog2(COLUMNS);
   localparam int ROW_W        = $clog2(ROWS);
   localparam int CW1          = COL_W + 1;
   localparam int CMP_W        = tmcw_pkg::COORD_W + 1;
   localparam int POS_W        = tmcw_pkg::POS_W;
   localparam int COLUMN_OUT_W = tmcw_pkg::COLUMN_OUT_W;
   localparam int ROW_OUT_W    = tmcw_pkg::ROW_OUT_W;
   localparam logic [ADDR_W-1:0] CELL_LAST    = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_LAST    = ADDR_W'((ROWS - 1) * COLUMNS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_START = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST     = ROW_W'(ROWS - 1);

   tmcw_pkg::ctrl_state_type state_ff, state_in;
   tmcw_pkg::opcode_type     op_ff, op_in;
   logic [tmcw_pkg::CHAR_W-1:0] ch_ff, ch_in;
   logic [COL_W-1:0]  col_ff, col_in, arg_col_ff, arg_col_in, col_clamped;
   logic [ROW_W-1:0]  row_ff, row_in, arg_row_ff, arg_row_in, row_clamped;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [tmcw_pkg::CELL_W-1:0] data_ff, data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]        rsp_pos_ff;
   logic [COLUMN_OUT_W-1:0] rsp_col_ff;
   logic [ROW_OUT_W-1:0]    rsp_row_ff;
   logic [tmcw_pkg::CELL_W-1:0] rsp_data_ff;

   logic [ADDR_W-1:0] cur_idx, arg_idx, next_idx;
   logic [CW1-1:0]    tab_sum, tab_col;
   logic [tmcw_pkg::CELL_W-1:0] blank;
   logic              line_feed, finish, slot_free, load_rsp;

   assign col_clamped = ({1'b0, req_column} >= CMP_W'(COLUMNS)) ? COL_LAST
                                                                : COL_W'(req_column);
   assign row_clamped = ({1'b0, req_row} >= CMP_W'(ROWS)) ? ROW_LAST : ROW_W'(req_row);

   assign cur_idx  = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign arg_idx  = ADDR_W'(arg_row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(arg_col_ff);
   assign next_idx = ADDR_W'(row_in) * ADDR_W'(COLUMNS) + ADDR_W'(col_in);

   // tab stops every four columns
   assign tab_sum = {1'b0, col_ff} + CW1'(4);
   assign tab_col = tab_sum & ~CW1'(3);

   assign blank     = tmcw_pkg::cell_of(attr, tmcw_pkg::CH_SPACE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmcw_pkg::ST_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      ch_ff      <= ch_in;
      arg_col_ff <= arg_col_in;
      arg_row_ff <= arg_row_in;
      data_ff    <= data_in;
      if (load_rsp) begin
         rsp_pos_ff  <= POS_W'(next_idx);
         rsp_col_ff  <= COLUMN_OUT_W'(col_in);
         rsp_row_ff  <= ROW_OUT_W'(row_in);
         rsp_data_ff <= data_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      ch_in      = ch_ff;
      arg_col_in = arg_col_ff;
      arg_row_in = arg_row_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      ptr_in     = ptr_ff;
      data_in    = data_ff;
      req_ready  = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = ptr_ff;
      wr_data    = blank;
      rd_en      = 1'b0;
      rd_addr    = arg_idx;
      line_feed  = 1'b0;
      finish     = 1'b0;
      load_rsp   = 1'b0;

      case (state_ff)
         tmcw_pkg::ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = tmcw_pkg::RESET_CELL;
            if (ptr_ff == CELL_LAST) begin
               ptr_in   = '0;
               state_in = tmcw_pkg::ST_IDLE;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         tmcw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = tmcw_pkg::opcode_type'(req_opcode);
               ch_in      = req_char_code;
               arg_col_in = col_clamped;
               arg_row_in = row_clamped;
               data_in    = '0;
               state_in   = tmcw_pkg::ST_EXEC;
            end
         end
         tmcw_pkg::ST_EXEC: begin
            case (op_ff)
               tmcw_pkg::OP_SET_CURSOR: begin
                  col_in = arg_col_ff;
                  row_in = arg_row_ff;
                  finish = 1'b1;
               end
               tmcw_pkg::OP_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  ptr_in   = '0;
                  state_in = tmcw_pkg::ST_FILL;
               end
               tmcw_pkg::OP_READ_CELL: begin
                  rd_en    = 1'b1;
                  rd_addr  = arg_idx;
                  state_in = tmcw_pkg::ST_READ;
               end
               default: begin
                  case (ch_ff)
                     tmcw_pkg::CH_NEWLINE: begin
                        line_feed = 1'b1;
                     end
                     tmcw_pkg::CH_RETURN: begin
                        col_in = '0;
                        finish = 1'b1;
                     end
                     tmcw_pkg::CH_BACKSPACE: begin
                        if (col_ff != '0) begin
                           col_in  = col_ff - COL_W'(1);
                           wr_en   = 1'b1;
                           wr_addr = cur_idx - ADDR_W'(1);
                           wr_data = blank;
                        end
                        finish = 1'b1;
                     end
                     tmcw_pkg::CH_TAB: begin
                        if (tab_col >= CW1'(COLUMNS)) begin
                           line_feed = 1'b1;
                        end else begin
                           col_in = tab_col[COL_W-1:0];
                           finish = 1'b1;
                        end
                     end
                     default: begin
                        wr_en   = 1'b1;
                        wr_addr = cur_idx;
                        wr_data = tmcw_pkg::cell_of(attr, ch_ff);
                        if (col_ff == COL_LAST) begin
                           line_feed = 1'b1;
                        end else begin
                           col_in = col_ff + COL_W'(1);
                           finish = 1'b1;
                        end
                     end
                  endcase
                  if (line_feed) begin
                     col_in = '0;
                     if (row_ff == ROW_LAST) begin
                        ptr_in   = '0;
                        state_in = tmcw_pkg::ST_COPY;
                     end else begin
                        row_in = row_ff + ROW_W'(1);
                        finish = 1'b1;
                     end
                  end
               end
            endcase
         end
         tmcw_pkg::ST_READ: begin
            data_in = rd_data;
            finish  = 1'b1;
         end
         tmcw_pkg::ST_COPY: begin
            // read one row below, write back what the previous read returned
            rd_en   = 1'b1;
            rd_addr = ptr_ff + ADDR_W'(COLUMNS);
            if (ptr_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff - ADDR_W'(1);
               wr_data = rd_data;
            end
            if (ptr_ff == COPY_LAST) begin
               state_in = tmcw_pkg::ST_COPY_TAIL;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         tmcw_pkg::ST_COPY_TAIL: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff;
            wr_data  = rd_data;
            ptr_in   = BOTTOM_START;
            state_in = tmcw_pkg::ST_FILL;
         end
         tmcw_pkg::ST_FILL: begin
            wr_en   = 1'b1;
            wr_data = blank;
            if (ptr_ff == CELL_LAST) begin
               finish = 1'b1;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         tmcw_pkg::ST_DONE: begin
            finish = 1'b1;
         end
         default: begin
            state_in = tmcw_pkg::ST_IDLE;
         end
      endcase

      // result goes to the output register when it is free, else wait
      if (finish) begin
         if (slot_free) begin
            load_rsp = 1'b1;
            state_in = tmcw_pkg::ST_IDLE;
         end else begin
            state_in = tmcw_pkg::ST_DONE;
         end
      end

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cursor_column   = rsp_col_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cell_data       = rsp_data_ff;

endmodule

// File: rtl/core/tmcw_checker.sv
// ----------------------------------------------------------------------------
// tmcw_checker: port level checks of the console writer
// beat accounting, response hold and cursor consistency
// ----------------------------------------------------------------------------
module tmcw_checker #(
   parameter int COLUMNS = tmcw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tmcw_pkg::DEFAULT_ROWS
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [tmcw_pkg::POS_W-1:0]        rsp_cursor_position,
   input logic [tmcw_pkg::COLUMN_OUT_W-1:0] rsp_cursor_column,
   input logic [tmcw_pkg::ROW_OUT_W-1:0]    rsp_cursor_row,
   input logic [tmcw_pkg::CELL_W-1:0]       rsp_cell_data
);

   localparam int POS_W = tmcw_pkg::POS_W;
   localparam bit FITS  = (COLUMNS <= 128) && (ROWS <= 32);

   // request beats taken minus response beats delivered
   logic [1:0]       pending_ff, pending_in;
   logic [POS_W-1:0] exp_pos;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready) begin
         pending_in = pending_in + 2'd1;
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = pending_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   assign exp_pos = POS_W'(int'(rsp_cursor_row) * COLUMNS + int'(rsp_cursor_column));

   // no response without a request in flight
   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response beat without outstanding request");

   // at most one request in work besides one waiting response
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> pending_ff < 2'd2)
      else $error("request taken with two results still owed");

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_position)
         && $stable(rsp_cursor_column) && $stable(rsp_cursor_row)
         && $stable(rsp_cell_data))
      else $error("stalled response changed");

   // cursor on screen and position consistent with column and row
   a_cursor_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !FITS || (int'(rsp_cursor_column) < COLUMNS
         && int'(rsp_cursor_row) < ROWS && rsp_cursor_position == exp_pos))
      else $error("cursor position inconsistent");

endmodule

bind text_mode_console_writer_core tmcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tmcw_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_cursor_position (rsp_ch.cursor_position),
   .rsp_cursor_column   (rsp_ch.cursor_column),
   .rsp_cursor_row      (rsp_ch.cursor_row),
   .rsp_cell_data       (rsp_ch.cell_data)
);

// File: tb/tb_text_mode_console_writer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_mode_console_writer_core: self-checking bench for the console writer
// A queue-fed driver sends request beats and a clocked monitor checks every
// response beat against a screen and cursor model kept inside the bench.
// A directed opening covers control characters, clamping and scrolling. Random
// phases then run under several attribute settings, with random stalls on
// both channels.
// ----------------------------------------------------------------------------
module tb_text_mode_console_writer_core;

   localparam int COLS         = tmcw_pkg::DEFAULT_COLUMNS;
   localparam int ROWS_N       = tmcw_pkg::DEFAULT_ROWS;
   localparam int CELLS        = COLS * ROWS_N;
   localparam int PHASES       = 6;
   localparam int PHASE_LEN    = 117;
   localparam int TIMEOUT_NS   = 80_000_000;
   localparam int CHAR_W       = tmcw_pkg::CHAR_W;
   localparam int COORD_W      = tmcw_pkg::COORD_W;
   localparam int POS_W        = tmcw_pkg::POS_W;
   localparam int COLUMN_OUT_W = tmcw_pkg::COLUMN_OUT_W;
   localparam int ROW_OUT_W    = tmcw_pkg::ROW_OUT_W;
   localparam int CELL_W       = tmcw_pkg::CELL_W;
   localparam int NIBBLE_W     = tmcw_pkg::NIBBLE_W;
   localparam int CSR_INDEX_W  = tmcw_pkg::CSR_INDEX_W;

   typedef struct packed {
      tmcw_pkg::opcode_type op;
      logic [CHAR_W-1:0]    ch;
      logic [COORD_W-1:0]   col;
      logic [COORD_W-1:0]   row;
   } console_cmd_type;

   typedef struct packed {
      logic [POS_W-1:0]        position;
      logic [COLUMN_OUT_W-1:0] column;
      logic [ROW_OUT_W-1:0]    row;
      logic [CELL_W-1:0]       cell_word;
   } cursor_report_type;

   logic clock;
   logic reset;

   tmcw_req_if req_ch ();
   tmcw_rsp_if rsp_ch ();
   tmcw_csr_if csr_ch ();

   text_mode_console_writer_core #(
      .COLUMNS (COLS),
      .ROWS    (ROWS_N)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // screen and cursor model
   logic [CELL_W-1:0]   screen_model [0:CELLS-1];
   int                  cur_col;
   int                  cur_row;
   logic [NIBBLE_W-1:0] fg_model;
   logic [NIBBLE_W-1:0] bg_model;

   // traffic bookkeeping
   console_cmd_type   pending_cmds [$];
   cursor_report_type expected_reports [$];
   console_cmd_type   wire_cmd;
   cursor_report_type oldest_report;
   int                sent_count;
   int                got_count;
   int                send_gap;
   int                take_gap;
   int                send_steady;
   int                take_steady;
   bit                drain_pause;
   int                mismatch_count;
   int                op_counts [4];
   int                scroll_count;
   int                attr_writes;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d responses still owed", expected_reports.size());
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------
   // model of the block
   // ---------------------------------------------------------------------

   // a space in the current colors
   function automatic logic [CELL_W-1:0] blank_cell();
      return {bg_model, fg_model, tmcw_pkg::CH_SPACE};
   endfunction

   // new line; past the last row everything moves up one row
   function automatic void line_feed_model();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS_N) begin
         for (int i = 0; i < (ROWS_N - 1) * COLS; i++)
            screen_model[i] = screen_model[i + COLS];
         for (int i = (ROWS_N - 1) * COLS; i < CELLS; i++)
            screen_model[i] = blank_cell();
         cur_row = ROWS_N - 1;
         scroll_count++;
      end
   endfunction

   function automatic void put_char_model(input logic [CHAR_W-1:0] ch);
      case (ch)
         tmcw_pkg::CH_NEWLINE: begin
            line_feed_model();
         end
         tmcw_pkg::CH_RETURN: begin
            cur_col = 0;
         end
         tmcw_pkg::CH_BACKSPACE: begin
            // column zero: left alone
            if (cur_col > 0) begin
               cur_col--;
               screen_model[cur_row * COLS + cur_col] = blank_cell();
            end
         end
         tmcw_pkg::CH_TAB: begin
            // next multiple of four, a new line once past the right edge
            cur_col = (cur_col + 4) & ~3;
            if (cur_col >= COLS)
               line_feed_model();
         end
         default: begin
            screen_model[cur_row * COLS + cur_col] = {bg_model, fg_model, ch};
            cur_col++;
            if (cur_col >= COLS)
               line_feed_model();
         end
      endcase
   endfunction

   // applies one request to the model and returns the response it owes
   function automatic cursor_report_type run_console_op(input console_cmd_type c);
      cursor_report_type rep;
      int                cl;
      int                rw;
      rep.cell_word = '0;
      cl = (c.col >= COLS) ? COLS - 1 : int'(c.col);
      rw = (c.row >= ROWS_N) ? ROWS_N - 1 : int'(c.row);
      op_counts[c.op]++;
      case (c.op)
         tmcw_pkg::OP_PUT_CHAR: begin
            put_char_model(c.ch);
         end
         tmcw_pkg::OP_SET_CURSOR: begin
            cur_col = cl;
            cur_row = rw;
         end
         tmcw_pkg::OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               screen_model[i] = blank_cell();
            cur_col = 0;
            cur_row = 0;
         end
         default: begin
            // read leaves the cursor where it is
            rep.cell_word = screen_model[rw * COLS + cl];
         end
      endcase
      rep.position = POS_W'(cur_row * COLS + cur_col);
      rep.column   = COLUMN_OUT_W'(cur_col);
      rep.row      = ROW_OUT_W'(cur_row);
      return rep;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // mostly back-to-back, some short gaps, a few long ones, and now and
   // then a stretch with no gaps at all
   function automatic int pick_gap(inout int steady_left);
      int r;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         steady_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // in range, hugging the far edge, or anything the field holds
   function automatic logic [COORD_W-1:0] pick_coord(input int limit);
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return COORD_W'($urandom_range(0, limit - 1));
      if (r < 70) return COORD_W'($urandom_range(limit - 3, limit - 1));
      return COORD_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [CHAR_W-1:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return CHAR_W'($urandom_range(0, 255));
      if (r < 67) return tmcw_pkg::CH_NEWLINE;
      if (r < 75) return tmcw_pkg::CH_RETURN;
      if (r < 87) return tmcw_pkg::CH_BACKSPACE;
      return tmcw_pkg::CH_TAB;
   endfunction

   // unused fields keep their random values
   function automatic console_cmd_type random_cmd();
      console_cmd_type c;
      int              r;
      c.ch  = CHAR_W'($urandom_range(0, 255));
      c.col = COORD_W'($urandom_range(0, 255));
      c.row = COORD_W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 62) begin
         c.op = tmcw_pkg::OP_PUT_CHAR;
         c.ch = pick_char();
      end else if (r < 76) begin
         c.op  = tmcw_pkg::OP_SET_CURSOR;
         c.col = pick_coord(COLS);
         c.row = pick_coord(ROWS_N);
      end else if (r < 78) begin
         c.op = tmcw_pkg::OP_CLEAR;
      end else begin
         c.op  = tmcw_pkg::OP_READ_CELL;
         c.col = pick_coord(COLS);
         c.row = pick_coord(ROWS_N);
      end
      return c;
   endfunction

   task automatic queue_cmd(input tmcw_pkg::opcode_type op, input logic [CHAR_W-1:0] ch,
                            input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
      pending_cmds.push_back('{op, ch, col, row});
   endtask

   // lines of text with the odd control character, mixed with single requests
   task automatic queue_random_phase(input int count);
      int made;
      int run;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 99) < 15) begin
            run = $urandom_range(4, 40);
            for (int k = 0; k < run && made < count; k++) begin
               queue_cmd(tmcw_pkg::OP_PUT_CHAR,
                         ($urandom_range(0, 9) == 0) ? pick_char()
                                                     : CHAR_W'($urandom_range(33, 126)),
                         COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)));
               made++;
            end
         end else begin
            pending_cmds.push_back(random_cmd());
            made++;
         end
      end
   endtask

   // register write beat; the upper data bits are junk on purpose
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [NIBBLE_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= {NIBBLE_W'($urandom_range(0, 15)), value};
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // everything sent and answered, then a quiet pause
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_ch.valid || expected_reports.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic note_mismatch(input string field_name, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s at %0t: expected %0h, got %0h",
                  field_name, $time, want, got);
   endtask

   // ---------------------------------------------------------------------
   // request driver, also tracks register beats for the model
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CELLS; i++)
            screen_model[i] = tmcw_pkg::RESET_CELL;
         cur_col       = 0;
         cur_row       = 0;
         fg_model      = tmcw_pkg::FOREGROUND_RESET;
         bg_model      = tmcw_pkg::BACKGROUND_RESET;
         sent_count    = 0;
         send_gap      = 0;
         send_steady   = 0;
         drain_pause   = 1'b0;
         req_ch.valid <= 1'b0;
      end else begin
         // register beat: only the two attribute nibbles exist
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               tmcw_pkg::REG_ATTR_FOREGROUND: fg_model = csr_ch.data[NIBBLE_W-1:0];
               tmcw_pkg::REG_ATTR_BACKGROUND: bg_model = csr_ch.data[NIBBLE_W-1:0];
               default: ;
            endcase
            attr_writes++;
         end
         // request beat taken: predict its response
         if (req_ch.valid && req_ch.ready) begin
            wire_cmd.op  = tmcw_pkg::opcode_type'(req_ch.opcode);
            wire_cmd.ch  = req_ch.char_code;
            wire_cmd.col = req_ch.column;
            wire_cmd.row = req_ch.row;
            expected_reports.push_back(run_console_op(wire_cmd));
            sent_count++;
         end
         // channel free for the next beat
         if (!req_ch.valid || req_ch.ready) begin
            if (drain_pause && got_count == sent_count)
               drain_pause = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (!drain_pause && pending_cmds.size() != 0) begin
               wire_cmd = pending_cmds.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.opcode    <= wire_cmd.op;
               req_ch.char_code <= wire_cmd.ch;
               req_ch.column    <= wire_cmd.col;
               req_ch.row       <= wire_cmd.row;
               send_gap    = pick_gap(send_steady);
               // once in a while hold off until every response is back
               drain_pause = ($urandom_range(0, 79) == 0);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // response monitor with random back-pressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         take_gap      = 0;
         take_steady   = 0;
         rsp_ch.ready <= 1'b0;
         got_count    <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_count <= got_count + 1;
            if (expected_reports.size() == 0) begin
               note_mismatch("unexpected response beat", '0, rsp_ch.cursor_position);
            end else begin
               oldest_report = expected_reports.pop_front();
               if (rsp_ch.cursor_position !== oldest_report.position)
                  note_mismatch("cursor_position", oldest_report.position,
                                rsp_ch.cursor_position);
               if (rsp_ch.cursor_column !== oldest_report.column)
                  note_mismatch("cursor_column", oldest_report.column, rsp_ch.cursor_column);
               if (rsp_ch.cursor_row !== oldest_report.row)
                  note_mismatch("cursor_row", oldest_report.row, rsp_ch.cursor_row);
               if (rsp_ch.cell_data !== oldest_report.cell_word)
                  note_mismatch("cell_data", oldest_report.cell_word, rsp_ch.cell_data);
            end
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            take_gap = pick_gap(take_steady);
         end
      end
   end

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      // known values on every input from time zero
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.opcode    = '0;
      req_ch.char_code = '0;
      req_ch.column    = '0;
      req_ch.row       = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.data      = '0;
      mismatch_count   = 0;
      scroll_count     = 0;
      attr_writes      = 0;
      got_count        = 0;
      foreach (op_counts[i]) op_counts[i] = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed opening under the reset colors
      queue_cmd(tmcw_pkg::OP_READ_CELL,  8'h00, 8'd0,   8'd0);    // untouched after reset
      queue_cmd(tmcw_pkg::OP_READ_CELL,  8'hFF, 8'd255, 8'd255);  // both clamped
      queue_cmd(tmcw_pkg::OP_PUT_CHAR,   8'h41, 8'hFF,  8'hFF);
      queue_cmd(tmcw_pkg::OP_PUT_CHAR,   8'hFF, 8'h00,  8'h00);
      queue_cmd(tmcw_pkg::OP_PUT_CHAR,   8'h00, 8'h00,  8'h00);   // zero byte is a cell
      queue_cmd(tmcw_pkg::OP_PUT_CHAR,   tmcw_pkg::CH_BACKSPACE, 8'd0, 8'd0);
      queue_cmd(tmcw_pkg::OP_READ_CELL,  8'h00, 8'd2,   8'd0);    // blanked by backspace
      queue_cmd(tmcw_pkg::OP_SET_CURSOR, 8'h00, 8'd0,   8'd5);
      queue_cmd(tmcw_pkg::OP_PUT_CHAR,   tmcw_pkg::CH_BACKSPACE, 8'd0, 8'd0); // no-op
      queue_cmd(tmcw_pkg::OP_PUT_CHAR,   tmcw_pkg::CH_TAB, 8'd0, 8'd0);
      queue_cmd(tmcw_pkg::OP_SET_CURSOR, 8'h00, 8'd77,  8'd3);
      queue_cmd(tmcw_pkg::OP_PUT_CHAR,   tmcw_pkg::CH_TAB, 8'd0, 8'd0); // off the edge
      queue_cmd(tmcw_pkg::OP_SET_CURSOR, 8'h00, 8'd255, 8'd0);    // column clamped
      queue_cmd(tmcw_pkg::OP_PUT_CHAR,   8'h5A, 8'd0, 8'd0);      // wraps to next line
      queue_cmd(tmcw_pkg::OP_SET_CURSOR, 8'h00, 8'd10,  8'd255);  // row clamped
      queue_cmd(tmcw_pkg::OP_PUT_CHAR,   tmcw_pkg::CH_RETURN, 8'd0, 8'd0);
      queue_cmd(tmcw_pkg::OP_SET_CURSOR, 8'h00, 8'd79,  8'd24);
      queue_cmd(tmcw_pkg::OP_PUT_CHAR,   8'h71, 8'd0, 8'd0);      // last cell: scroll
      queue_cmd(tmcw_pkg::OP_PUT_CHAR,   tmcw_pkg::CH_NEWLINE, 8'd0, 8'd0); // scrolls
      queue_cmd(tmcw_pkg::OP_READ_CELL,  8'h00, 8'd79,  8'd22);
      queue_cmd(tmcw_pkg::OP_CLEAR,      8'hA5, 8'hC3,  8'h3C);
      queue_cmd(tmcw_pkg::OP_READ_CELL,  8'h00, 8'd255, 8'd0);
      queue_cmd(tmcw_pkg::OP_SET_CURSOR, 8'h00, 8'd128, 8'd128);
      queue_cmd(tmcw_pkg::OP_READ_CELL,  8'h00, 8'd0,   8'd24);
      wait_idle();

      // random phases, colors changed between them
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               write_reg(tmcw_pkg::REG_ATTR_FOREGROUND, 4'hF);
               write_reg(tmcw_pkg::REG_ATTR_BACKGROUND, 4'hF);
            end
            1: begin
               write_reg(tmcw_pkg::REG_ATTR_FOREGROUND, 4'h0);
               write_reg(tmcw_pkg::REG_ATTR_BACKGROUND, 4'h0);
            end
            2: begin
               write_reg(tmcw_pkg::REG_ATTR_BACKGROUND, 4'hF);
            end
            3: begin
               write_reg(tmcw_pkg::REG_ATTR_FOREGROUND, 4'hF);
               write_reg(tmcw_pkg::REG_ATTR_BACKGROUND, 4'h0);
            end
            default: begin
               write_reg(tmcw_pkg::REG_ATTR_FOREGROUND, NIBBLE_W'($urandom_range(0, 15)));
               write_reg(tmcw_pkg::REG_ATTR_BACKGROUND, NIBBLE_W'($urandom_range(0, 15)));
            end
         endcase
         // an index with no register behind it must change nothing
         write_reg(CSR_INDEX_W'($urandom_range(2, 15)), NIBBLE_W'($urandom_range(0, 15)));
         queue_random_phase(PHASE_LEN);
         wait_idle();
      end

      // quiet period long enough for a stray scroll or clear to finish
      repeat (CELLS + 16) @(negedge clock);

      $display("run covered %0d requests: %0d puts, %0d cursor moves, %0d clears, %0d reads",
               sent_count, op_counts[tmcw_pkg::OP_PUT_CHAR],
               op_counts[tmcw_pkg::OP_SET_CURSOR],
               op_counts[tmcw_pkg::OP_CLEAR], op_counts[tmcw_pkg::OP_READ_CELL]);
      $display("%0d scrolls, %0d register beats, %0d mismatches",
               scroll_count, attr_writes, mismatch_count);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: text_mode_console_writer_core.f
rtl/core/tmcw_pkg.sv
rtl/core/tmcw_ifs.sv
rtl/core/tmcw_screen_ram.sv
rtl/core/tmcw_ctrl.sv
rtl/core/text_mode_console_writer_core.sv
rtl/core/tmcw_checker.sv
tb/tb_text_mode_console_writer_core.sv
